// ===== src/sha512_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned BlkWords  = 16;
  localparam int unsigned HashWords = 8;
  localparam int unsigned Rounds    = 80;

  typedef logic [WordW-1:0] word_t;

  localparam word_t RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam word_t InitHash [HashWords] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [6:0] LenFieldAt = 7'd112;

  typedef struct packed {
    logic       load_en;
    logic [2:0] load_idx;
    logic       round_en;
    logic [6:0] round_idx;
  } rnd_ctl_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PAD    = 9'b000000010,
    ST_ZERO   = 9'b000000100,
    ST_LEN    = 9'b000001000,
    ST_LOAD   = 9'b000010000,
    ST_ROUND  = 9'b000100000,
    ST_WB     = 9'b001000000,
    ST_OUT_RD = 9'b010000000,
    ST_OUT_LD = 9'b100000000
  } state_e;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

endpackage
`default_nettype wire

// ===== src/sha512_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sha512_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha512_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

// ===== src/sha512_blkbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sha512_blkbuf (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [3:0]          waddr_i,
  input  wire sha512_pkg::word_t   wdata_i,
  input  wire logic [3:0]          raddr_i,
  output sha512_pkg::word_t        rdata_o
);
  import sha512_pkg::*;

  word_t mem [BlkWords];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/sha512_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sha512_round (
  input  wire logic                  clk_i,
  input  wire sha512_pkg::rnd_ctl_t  ctl_i,
  input  wire sha512_pkg::word_t     load_data_i,
  input  wire sha512_pkg::word_t     blk_word_i,
  input  wire logic [2:0]            wb_idx_i,
  output sha512_pkg::word_t          wb_word_o
);
  import sha512_pkg::*;

  word_t work_q [HashWords];
  word_t sched_q [BlkWords];
  word_t w, ssig0, ssig1, bsig0, bsig1, ch, maj, t1, t2;

  always_comb begin
    ssig0 = rotr(sched_q[1], 1) ^ rotr(sched_q[1], 8) ^ (sched_q[1] >> 7);
    ssig1 = rotr(sched_q[14], 19) ^ rotr(sched_q[14], 61) ^ (sched_q[14] >> 6);
    if (ctl_i.round_idx < 7'd16) begin
      w = blk_word_i;
    end else begin
      w = sched_q[0] + ssig0 + sched_q[9] + ssig1;
    end
    bsig1 = rotr(work_q[4], 14) ^ rotr(work_q[4], 18) ^ rotr(work_q[4], 41);
    bsig0 = rotr(work_q[0], 28) ^ rotr(work_q[0], 34) ^ rotr(work_q[0], 39);
    ch    = work_q[6] ^ (work_q[4] & (work_q[5] ^ work_q[6]));
    maj   = (work_q[0] & work_q[1]) | (work_q[2] & (work_q[0] | work_q[1]));
    t1    = work_q[7] + bsig1 + ch + RoundK[ctl_i.round_idx] + w;
    t2    = bsig0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_en) begin
      work_q[ctl_i.load_idx] <= load_data_i;
    end else if (ctl_i.round_en) begin
      for (int j = 1; j < HashWords; j++) begin
        if (j != 4) begin
          work_q[j] <= work_q[j-1];
        end
      end
      work_q[4] <= work_q[3] + t1;
      work_q[0] <= t1 + t2;
      for (int i = 0; i < BlkWords - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[BlkWords-1] <= w;
    end
  end

  assign wb_word_o = work_q[wb_idx_i];

endmodule
`default_nettype wire

// ===== src/sha512_hash_core_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a word that fills no block is taken without a stall; one that completes a 128-byte block stalls
// input while the block is loaded, compressed in 80 rounds at one per cycle and written back
// last word: padding writes one word a cycle while no block is compressed, one or two
// compressions in all, then 8 digest items, each loaded once the previous one is taken;
// full input words are held up by the round loop; reset clears control, counters and output
// valid; hash memory reads as the initial values after reset and after each digest, with no clearing pass
module sha512_hash_core_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sha512_msg_if.sink  msg_i,
  sha512_dig_if.source dig_o
);
  import sha512_pkg::*;

  state_e     state_q, state_d, ret_q, ret_d;
  logic [6:0] cnt_q, cnt_d;
  logic [6:0] fill_q, fill_d;
  word_t      part_q, part_d;
  word_t      total_q, total_d;
  logic       fresh_q, fresh_d;
  logic       out_valid_q, out_valid_d;
  word_t      out_word_q;
  logic [2:0] out_idx_q;
  logic       out_last_q;
  logic       out_load;

  // hash memory
  word_t      hash_mem [HashWords];
  word_t      hash_rdata_q;
  logic       hash_we;
  word_t      hash_wdata;
  logic [2:0] prev_idx;
  word_t      hash_cur;

  // gather path
  word_t      g_word, g_mask, g_bytes;
  logic [3:0] g_n, span;
  logic [127:0] win;
  logic       g_full;

  logic       blk_we;
  logic [3:0] blk_waddr;
  word_t      blk_wdata, blk_rdata;
  logic [3:0] blk_raddr;
  rnd_ctl_t   rctl;
  word_t      wb_word;

  assign prev_idx = 3'(cnt_q - 7'd1);
  assign hash_cur = fresh_q ? InitHash[prev_idx] : hash_rdata_q;

  always_comb begin
    g_n    = (msg_i.valid_bytes > 4'd8) ? 4'd8 : msg_i.valid_bytes;
    g_word = msg_i.message_word;
    if (state_q == ST_PAD) begin
      g_n    = 4'd1;
      g_word = {PadByte, 56'b0};
    end
    g_mask  = ~({WordW{1'b1}} >> {g_n, 3'b000});
    g_bytes = g_word & g_mask;
    win     = {part_q, 64'b0} | ({g_bytes, 64'b0} >> {fill_q[2:0], 3'b000});
    span    = {1'b0, fill_q[2:0]} + g_n;
    g_full  = span[3];
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    part_d      = part_q;
    total_d     = total_q;
    fresh_d     = fresh_q;
    out_load    = 1'b0;
    blk_we      = 1'b0;
    blk_waddr   = fill_q[6:3];
    blk_wdata   = win[127:64];
    hash_we     = 1'b0;
    hash_wdata  = hash_cur + wb_word;
    rctl        = '0;
    rctl.load_idx  = prev_idx;
    rctl.round_idx = cnt_q;
    blk_raddr   = (state_q == ST_ROUND) ? cnt_q[3:0] + 4'd1 : 4'd0;
    msg_i.ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE, ST_PAD: begin
        if (state_q == ST_PAD || msg_i.valid) begin
          if (state_q == ST_IDLE) begin
            total_d = total_q + 64'(g_n);
          end
          blk_we = g_full;
          fill_d = fill_q + 7'(g_n);
          part_d = g_full ? win[63:0] : win[127:64];
          if (state_q == ST_PAD) begin
            ret_d   = ST_ZERO;
            state_d = ST_ZERO;
          end else begin
            ret_d   = msg_i.last_word ? ST_PAD : ST_IDLE;
            state_d = ret_d;
          end
          if (g_full && fill_q[6:3] == 4'd15) begin
            cnt_d   = '0;
            state_d = ST_LOAD;
          end
        end
      end
      ST_ZERO: begin
        // flush the partial word and zero-fill up to the length field
        blk_we    = 1'b1;
        blk_wdata = part_q;
        part_d    = '0;
        fill_d    = {fill_q[6:3] + 4'd1, 3'b000};
        if (fill_q == LenFieldAt) begin
          state_d = ST_LEN;
        end else if (fill_q[6:3] == 4'd15) begin
          ret_d   = ST_ZERO;
          cnt_d   = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LEN: begin
        blk_we    = 1'b1;
        blk_waddr = 4'd15;
        blk_wdata = {total_q[60:0], 3'b000};
        fill_d    = '0;
        ret_d     = ST_OUT_RD;
        cnt_d     = '0;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        rctl.load_en = (cnt_q != 7'd0);
        if (cnt_q == 7'd8) begin
          cnt_d   = '0;
          state_d = ST_ROUND;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_ROUND: begin
        rctl.round_en = 1'b1;
        if (cnt_q == 7'(Rounds - 1)) begin
          cnt_d   = '0;
          state_d = ST_WB;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_WB: begin
        hash_we = (cnt_q != 7'd0);
        if (cnt_q == 7'd8) begin
          fresh_d = 1'b0;
          cnt_d   = '0;
          state_d = ret_q;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_OUT_RD: begin
        if (!out_valid_q) begin
          state_d = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        out_load = 1'b1;
        if (cnt_q == 7'd7) begin
          fresh_d = 1'b1;
          total_d = '0;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d   = cnt_q + 7'd1;
          state_d = ST_OUT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hash_we) begin
      hash_mem[prev_idx] <= hash_wdata;
    end
    hash_rdata_q <= hash_mem[cnt_q[2:0]];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (dig_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      cnt_q       <= '0;
      fill_q      <= '0;
      part_q      <= '0;
      total_q     <= '0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      part_q      <= part_d;
      total_q     <= total_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= hash_rdata_q;
      out_idx_q  <= cnt_q[2:0];
      out_last_q <= (cnt_q == 7'd7);
    end
  end

  assign dig_o.valid        = out_valid_q;
  assign dig_o.digest_word  = out_word_q;
  assign dig_o.digest_index = out_idx_q;
  assign dig_o.digest_last  = out_last_q;

  sha512_blkbuf u_blkbuf (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  sha512_round u_round (
    .clk_i       (clk_i),
    .ctl_i       (rctl),
    .load_data_i (hash_cur),
    .blk_word_i  (blk_rdata),
    .wb_idx_i    (prev_idx),
    .wb_word_o   (wb_word)
  );

`ifndef SYNTHESIS
  a_len_at_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LEN |-> fill_q == 7'd120)
    else $error("length word not at end of block");
  a_no_buf_write_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND || state_q == ST_LOAD || state_q == ST_WB) |-> !blk_we)
    else $error("block buffer written during compression");
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_idx_q == 3'd7)
    else $error("digest last flag on wrong index");
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q)
    else $error("digest item overwritten");
`endif

endmodule
`default_nettype wire
